// ===== rtl/core/psi_pkg.sv =====
// Shared types and constants for the parity split sorted insert core.
// Used by psi_ctrl, psi_datapath and parity_split_sorted_insert_core.
`timescale 1ns / 1ps
`default_nettype none

package psi_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int NUM_STORES  = 2;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [IDX_W-1:0]              idx_t;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_DUMP   = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STAT_INSERTED   = 2'd0,
        STAT_DROPPED    = 2'd1,
        STAT_DUMP_ENTRY = 2'd2,
        STAT_DUMP_EMPTY = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        func_t  func;
        value_t value;
    } in_beat_t;

    typedef struct packed {
        status_t status;
        logic    from_odd;
        value_t  entry_value;
        logic    end_of_store;
        logic    last;
    } out_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic insert;
        logic load;
        logic dump;
        logic dump_odd;
        idx_t dump_idx;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic dump_end;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/psi_datapath.sv =====
// Datapath: the two sorted stores, their fill counts and the output register.
// Depends on psi_pkg; driven by commands from psi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module psi_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  psi_pkg::in_beat_t    in_data,
    input  psi_pkg::cmd_t        cmd,
    output psi_pkg::sts_t        sts,
    output psi_pkg::out_beat_t   out_data
);

    psi_pkg::value_t store_reg  [psi_pkg::NUM_STORES][psi_pkg::STORE_DEPTH];
    psi_pkg::value_t store_next [psi_pkg::NUM_STORES][psi_pkg::STORE_DEPTH];
    psi_pkg::cnt_t   cnt_reg    [psi_pkg::NUM_STORES];
    psi_pkg::cnt_t   cnt_next   [psi_pkg::NUM_STORES];
    logic            keep       [psi_pkg::NUM_STORES][psi_pkg::STORE_DEPTH];
    logic            full       [psi_pkg::NUM_STORES];
    psi_pkg::out_beat_t out_reg;
    psi_pkg::out_beat_t out_next;

    logic            ins_odd;
    psi_pkg::cnt_t   dump_cnt;
    logic            dump_empty;
    logic            dump_end;

    assign ins_odd = in_data.value[0];

    // Compare the new value against every entry in parallel and shift up behind it
    always_comb
    begin
        logic            prev_keep;
        psi_pkg::value_t prev_entry;
        prev_keep  = 1'b1;
        prev_entry = in_data.value;
        for (int s = 0; s < psi_pkg::NUM_STORES; s++)
        begin
            full[s]     = (cnt_reg[s] == psi_pkg::CNT_W'(psi_pkg::STORE_DEPTH));
            cnt_next[s] = cnt_reg[s];
            prev_keep   = 1'b1;
            prev_entry  = in_data.value;
            for (int i = 0; i < psi_pkg::STORE_DEPTH; i++)
            begin
                keep[s][i] = (psi_pkg::CNT_W'(i) < cnt_reg[s]) &&
                             (store_reg[s][i] < in_data.value);
                store_next[s][i] = store_reg[s][i];
                if (cmd.insert && (1'(s) == ins_odd) && !full[s])
                begin
                    if (keep[s][i])
                        store_next[s][i] = store_reg[s][i];
                    else if (prev_keep)
                        store_next[s][i] = in_data.value;
                    else
                        store_next[s][i] = prev_entry;
                end
                prev_keep  = keep[s][i];
                prev_entry = store_reg[s][i];
            end
            if (cmd.insert && (1'(s) == ins_odd) && !full[s])
                cnt_next[s] = cnt_reg[s] + psi_pkg::CNT_W'(1);
        end
    end

    // Dump position status
    assign dump_cnt   = cnt_reg[cmd.dump_odd];
    assign dump_empty = (dump_cnt == '0);
    assign dump_end   = dump_empty ||
                        ((psi_pkg::CNT_W'(cmd.dump_idx) + psi_pkg::CNT_W'(1)) == dump_cnt);
    assign sts.dump_end = dump_end;

    // Build the next result beat
    always_comb
    begin
        out_next = out_reg;
        if (cmd.load)
        begin
            if (cmd.dump)
            begin
                out_next.status       = dump_empty ? psi_pkg::STAT_DUMP_EMPTY
                                                   : psi_pkg::STAT_DUMP_ENTRY;
                out_next.from_odd     = cmd.dump_odd;
                out_next.entry_value  = dump_empty ? '0
                                                   : store_reg[cmd.dump_odd][cmd.dump_idx];
                out_next.end_of_store = dump_end;
                out_next.last         = dump_end && cmd.dump_odd;
            end
            else
            begin
                out_next.status       = full[ins_odd] ? psi_pkg::STAT_DROPPED
                                                      : psi_pkg::STAT_INSERTED;
                out_next.from_odd     = ins_odd;
                out_next.entry_value  = in_data.value;
                out_next.end_of_store = 1'b0;
                out_next.last         = 1'b1;
            end
        end
    end

    // Fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < psi_pkg::NUM_STORES; s++)
                cnt_reg[s] <= '0;
        end
        else
        begin
            for (int s = 0; s < psi_pkg::NUM_STORES; s++)
                cnt_reg[s] <= cnt_next[s];
        end
    end

    // Store entries and result payload
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psi_ctrl.sv =====
// Controller: input/output handshake, dump sequencing and output valid.
// Depends on psi_pkg; drives psi_datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module psi_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  psi_pkg::func_t     in_func,
    output logic               out_valid,
    input  wire                out_ready,
    input  psi_pkg::sts_t      sts,
    output psi_pkg::cmd_t      cmd
);

    psi_pkg::state_t state_reg;
    psi_pkg::state_t state_next;
    logic            dump_odd_reg;
    logic            dump_odd_next;
    psi_pkg::idx_t   dump_idx_reg;
    psi_pkg::idx_t   dump_idx_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        dump_odd_next = dump_odd_reg;
        dump_idx_next = dump_idx_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.dump_odd  = dump_odd_reg;
        cmd.dump_idx  = dump_idx_reg;
        unique case (state_reg)
            psi_pkg::ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    if (in_func == psi_pkg::FUNC_INSERT)
                    begin
                        cmd.insert = 1'b1;
                        cmd.load   = 1'b1;
                    end
                    else
                    begin
                        state_next    = psi_pkg::ST_DUMP;
                        dump_odd_next = 1'b0;
                        dump_idx_next = '0;
                    end
                end
            end
            psi_pkg::ST_DUMP:
            begin
                if (slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.dump = 1'b1;
                    if (sts.dump_end)
                    begin
                        dump_idx_next = '0;
                        if (dump_odd_reg)
                            state_next = psi_pkg::ST_IDLE;
                        else
                            dump_odd_next = 1'b1;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + psi_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = psi_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the beat until taken, set it on every load
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psi_pkg::ST_IDLE;
            dump_odd_reg  <= 1'b0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dump_odd_reg  <= dump_odd_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A new beat must never overwrite one still waiting
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("result beat loaded over a pending beat");

    // No input is taken while a dump is being listed
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psi_pkg::ST_DUMP) |-> !in_ready)
        else $error("input accepted during dump");

    // The final odd store beat ends the dump
    a_dump_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.dump && cmd.dump_odd && sts.dump_end)
            |=> (state_reg == psi_pkg::ST_IDLE))
        else $error("dump did not end after last beat");

    // The even store is always listed before the odd store
    a_even_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == psi_pkg::ST_DUMP) |-> !dump_odd_reg)
        else $error("dump started on the odd store");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/parity_split_sorted_insert_core.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_ready    in_data  (func, value)
// out      out_valid/out_ready  out_data (status, from_odd, entry_value, end_of_store, last)
//
// An insert compares all store entries in parallel and shifts the tail up in the
// same cycle; its status beat is registered at the accepting edge and offered
// from the next cycle on.
// A dump lists max(1, even count) + max(1, odd count) beats from the output register,
// one per cycle while the output is not stalled, once the controller is in ST_DUMP;
// it takes no input until its last beat is loaded.
// A stalled output holds the result register and blocks the next input.
// Reset clears both fill counts and the control state; store entries are not reset.
//
// Top level: joins psi_ctrl and psi_datapath. Depends on psi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module parity_split_sorted_insert_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  psi_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output psi_pkg::out_beat_t   out_data
);

    psi_pkg::cmd_t cmd;
    psi_pkg::sts_t sts;

    // Sequencing and handshake
    psi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_func   (in_data.func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores and result register
    psi_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/parity_split_sorted_insert_core_test.sv =====
// Self-checking bench for parity_split_sorted_insert_core: directed table, then random beats.
// Keeps its own sorted even/odd lists to predict every result beat.
// Depends on psi_pkg and the core RTL only.
`timescale 1ns / 1ps

module parity_split_sorted_insert_core_test;

    localparam int HALF_PERIOD      = 6;
    localparam int RANDOM_ITEMS     = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_AFTER  = 250;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam longint LIMIT_NS     = 64'd24_000_000;

    typedef struct {
        psi_pkg::in_beat_t  stim;
        int                 n_typed;
        psi_pkg::out_beat_t typed [2];
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    psi_pkg::in_beat_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    psi_pkg::out_beat_t out_data;

    // Model lists indexed by parity: 0 even, 1 odd
    psi_pkg::value_t    sorted_vals [2][$];
    psi_pkg::out_beat_t fresh_beats [$];
    psi_pkg::out_beat_t pending_beats [$];
    dir_row_t           dir_rows [$];

    int tx_idle_pct = 10;
    int rx_idle_pct = 88;
    int items_taken = 0;
    int fail_count  = 0;

    parity_split_sorted_insert_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic psi_pkg::out_beat_t mk_beat(psi_pkg::status_t st, logic odd,
                                                   psi_pkg::value_t v, logic eos,
                                                   logic lst);
        psi_pkg::out_beat_t b;
        b.status       = st;
        b.from_odd     = odd;
        b.entry_value  = v;
        b.end_of_store = eos;
        b.last         = lst;
        return b;
    endfunction

    function automatic void add_row(psi_pkg::func_t f, psi_pkg::value_t v, int n_typed = 0,
                                    psi_pkg::out_beat_t e0 = '0,
                                    psi_pkg::out_beat_t e1 = '0);
        dir_row_t row;
        row.stim.func  = f;
        row.stim.value = v;
        row.n_typed    = n_typed;
        row.typed[0]   = e0;
        row.typed[1]   = e1;
        dir_rows.push_back(row);
    endfunction

    // Update the sorted lists and build the result beats of one accepted input
    function automatic void predict_results(psi_pkg::in_beat_t b);
        int s;
        int pos;
        int n;
        fresh_beats.delete();
        if (b.func == psi_pkg::FUNC_INSERT)
        begin
            s = int'(b.value[0]);
            if (sorted_vals[s].size() >= psi_pkg::STORE_DEPTH)
            begin
                fresh_beats.push_back(mk_beat(psi_pkg::STAT_DROPPED, 1'(s), b.value,
                                              1'b0, 1'b1));
            end
            else
            begin
                // new value lands in front of its equals
                pos = 0;
                while (pos < sorted_vals[s].size() &&
                       $signed(sorted_vals[s][pos]) < $signed(b.value))
                    pos++;
                sorted_vals[s].insert(pos, b.value);
                fresh_beats.push_back(mk_beat(psi_pkg::STAT_INSERTED, 1'(s), b.value,
                                              1'b0, 1'b1));
            end
        end
        else
        begin
            for (s = 0; s < 2; s++)
            begin
                n = sorted_vals[s].size();
                if (n == 0)
                    fresh_beats.push_back(mk_beat(psi_pkg::STAT_DUMP_EMPTY, 1'(s), '0,
                                                  1'b1, s == 1));
                else
                    for (pos = 0; pos < n; pos++)
                        fresh_beats.push_back(mk_beat(psi_pkg::STAT_DUMP_ENTRY, 1'(s),
                                                      sorted_vals[s][pos], pos == n - 1,
                                                      pos == n - 1 && s == 1));
            end
        end
    endfunction

    function automatic psi_pkg::value_t pick_value();
        psi_pkg::value_t edges [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001};
        int              kind;
        int              s;
        kind = $urandom_range(99);
        s    = $urandom_range(1);
        if (kind < 15)
            return edges[$urandom_range(5)];
        if (kind < 40)
            return psi_pkg::value_t'(int'($urandom_range(200)) - 100);
        if (kind < 60 && sorted_vals[s].size() != 0)
            return sorted_vals[s][$urandom_range(sorted_vals[s].size() - 1)];
        return psi_pkg::value_t'($urandom);
    endfunction

    // Offer one input beat from a falling edge; return at the falling edge after acceptance
    task automatic offer_item(input dir_row_t row);
        int k;
        while (roll(tx_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= row.stim;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_results(row.stim);
        if (row.n_typed != 0)
        begin
            for (k = 0; k < row.n_typed; k++)
                pending_beats.push_back(row.typed[k]);
        end
        else
        begin
            for (k = 0; k < fresh_beats.size(); k++)
                pending_beats.push_back(fresh_beats[k]);
        end
        items_taken++;
        @(negedge clk);
    endtask

    function automatic void report_field(string name, longint want_v, longint got_v);
        $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
        fail_count++;
    endfunction

    // Compare each output beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        psi_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d, value %0d",
                       out_data.status, out_data.entry_value);
                fail_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_data.status !== want.status)
                    report_field("status", want.status, out_data.status);
                if (out_data.from_odd !== want.from_odd)
                    report_field("from_odd", want.from_odd, out_data.from_odd);
                if (out_data.entry_value !== want.entry_value)
                    report_field("entry_value", want.entry_value, out_data.entry_value);
                if (out_data.end_of_store !== want.end_of_store)
                    report_field("end_of_store", want.end_of_store, out_data.end_of_store);
                if (out_data.last !== want.last)
                    report_field("last", want.last, out_data.last);
            end
        end
    end

    // Drive out_ready: random stalls plus one long hold to back up the input
    initial
    begin : drain_side
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && items_taken >= LONG_HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !roll(rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        psi_pkg::value_t odd_fill [10];
        dir_row_t        row;
        int              n;

        odd_fill = '{32'd1001, -32'sd77, 32'd3, 32'd999999, -32'sd13,
                     32'd41, 32'd7, -32'sd5, 32'd63, 32'd123457};

        // Empty dump right after reset gives two empty markers
        add_row(psi_pkg::FUNC_DUMP, '0, 2,
                mk_beat(psi_pkg::STAT_DUMP_EMPTY, 1'b0, '0, 1'b1, 1'b0),
                mk_beat(psi_pkg::STAT_DUMP_EMPTY, 1'b1, '0, 1'b1, 1'b1));
        // Extremes of the value range
        add_row(psi_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1,
                mk_beat(psi_pkg::STAT_INSERTED, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1));
        add_row(psi_pkg::FUNC_INSERT, 32'h8000_0000, 1,
                mk_beat(psi_pkg::STAT_INSERTED, 1'b0, 32'h8000_0000, 1'b0, 1'b1));
        add_row(psi_pkg::FUNC_INSERT, 32'h0000_0000, 1,
                mk_beat(psi_pkg::STAT_INSERTED, 1'b0, 32'h0000_0000, 1'b0, 1'b1));
        add_row(psi_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1,
                mk_beat(psi_pkg::STAT_INSERTED, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1));
        // Equal values and neighbors of the extremes
        add_row(psi_pkg::FUNC_INSERT, 32'd1);
        add_row(psi_pkg::FUNC_INSERT, 32'd5);
        add_row(psi_pkg::FUNC_INSERT, 32'd5);
        add_row(psi_pkg::FUNC_INSERT, -32'sd2);
        add_row(psi_pkg::FUNC_INSERT, 32'h7FFF_FFFE);
        add_row(psi_pkg::FUNC_INSERT, 32'h8000_0001);
        add_row(psi_pkg::FUNC_DUMP, 32'hDEAD_BEEF);
        // Fill the odd store, then overflow it
        for (n = 0; n < 10; n++)
            add_row(psi_pkg::FUNC_INSERT, odd_fill[n]);
        add_row(psi_pkg::FUNC_INSERT, 32'd9, 1,
                mk_beat(psi_pkg::STAT_DROPPED, 1'b1, 32'd9, 1'b0, 1'b1));
        add_row(psi_pkg::FUNC_DUMP, '0);

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < dir_rows.size(); n++)
            offer_item(dir_rows[n]);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
            begin
                tx_idle_pct = 88;
                rx_idle_pct = 10;
            end
            if (n == 200)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            row.n_typed    = 0;
            row.stim.func  = roll(12) ? psi_pkg::FUNC_DUMP : psi_pkg::FUNC_INSERT;
            row.stim.value = pick_value();
            offer_item(row);
        end
        in_valid <= 1'b0;

        // Drain outstanding beats, then watch for strays
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
